### rtl/core/mmat_pkg.sv
package mmat_pkg;

    // Field widths of the command and result words
    localparam int IFACE_W  = 4;
    localparam int GROUP_W  = 32;
    localparam int TIME_W   = 32;
    localparam int EXPIRY_W = 16;
    localparam int COUNT_W  = 7;
    localparam int CMD_W    = 2;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 7'd127;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 16'd260;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_REPORT = 2'd0,
        CMD_LEAVE  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_SWEEP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_HOLD = 2'd2
    } t_state;

    // Token that walks the cell chain, one cell per cycle
    typedef struct packed {
        logic               active;
        logic               hit;
        logic               claimed;
        logic [COUNT_W-1:0] count;
    } t_tok;

    // Command key held steady for all cells during a walk
    typedef struct packed {
        t_cmd                cmd;
        logic                en;
        logic [IFACE_W-1:0]  iface;
        logic [GROUP_W-1:0]  group;
        logic [TIME_W-1:0]   now;
        logic [EXPIRY_W-1:0] expiry;
    } t_bcast;

    // End-of-walk decision for a tentatively claimed slot
    typedef struct packed {
        logic fire;
        logic keep;
    } t_commit;

endpackage

### rtl/core/multicast_membership_aging_table_unit.sv
// Multicast membership table with aging. Each slot of the table is one cell in a
// chain; a command word becomes a token that visits the cells in order, one cell per
// clock. Report, leave, query and sweep each register their result once the token
// leaves the last cell, where it may wait on m_axis_tready before it is sent out.
// The command word carries the opcode in s_axis_tuser (0 report, 1 leave, 2 query,
// 3 sweep). A report refreshes a matching entry or fills the lowest free slot; with
// no free slot it is dropped and answers status 1. A sweep removes every entry older
// than the expiry register and returns the count removed, saturating at 127.
// Interfaces at or above IFACE_COUNT are ignored by report, leave and query.
// The expiry register resets to 260 and should only be written with no command in
// flight. The table comes out of reset empty with no clearing pass.
module multicast_membership_aging_table_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int IFACE_COUNT = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // command stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [3:0] iface_index, [35:4] mcast_group, [67:36] now_seconds, [71:68] zero
    input  logic [mmat_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] command
    input  logic [mmat_pkg::CMD_W-1:0]         s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] found, [1] status, [8:2] expired_count, [15:9] zero
    output logic [mmat_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // expiry register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mmat_pkg::EXPIRY_W-1:0]      i_cfg_data
);

    localparam int RES_W = 2 + mmat_pkg::COUNT_W;

    mmat_pkg::t_state                r_state;
    mmat_pkg::t_state                n_state;
    logic [mmat_pkg::EXPIRY_W-1:0]   r_expiry;
    mmat_pkg::t_bcast                r_bc;
    logic                            r_launch;
    logic                            w_accept;
    logic                            w_in_range;
    mmat_pkg::t_tok                  w_tok [TABLE_DEPTH+1];
    mmat_pkg::t_bcast                w_bc;
    mmat_pkg::t_commit               w_commit;
    mmat_pkg::t_tok                  w_last;
    logic [RES_W-1:0]                w_res;
    logic [RES_W-1:0]                r_res;
    logic                            w_res_we;
    logic                            r_m_valid;
    logic                            n_m_valid;
    logic [RES_W-1:0]                r_m_res;
    logic [RES_W-1:0]                n_m_res;
    logic                            w_out_free;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_in_range = int'(s_axis_tdata[mmat_pkg::IFACE_W-1:0]) < IFACE_COUNT;

    // Expiry register, always ready
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= mmat_pkg::EXPIRY_RESET;
        end else if (i_cfg_valid) begin
            r_expiry <= i_cfg_data;
        end
    end

    // Latch the command key and launch a token into the first cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= 1'b0;
        end else begin
            r_launch <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bc.cmd    <= mmat_pkg::t_cmd'(s_axis_tuser);
            r_bc.en     <= w_in_range;
            r_bc.iface  <= s_axis_tdata[mmat_pkg::IFACE_W-1:0];
            r_bc.group  <= s_axis_tdata[mmat_pkg::IFACE_W +: mmat_pkg::GROUP_W];
            r_bc.now    <= s_axis_tdata[mmat_pkg::IFACE_W+mmat_pkg::GROUP_W +: mmat_pkg::TIME_W];
            r_bc.expiry <= '0;
        end
    end

    always_comb begin
        w_bc        = r_bc;
        w_bc.expiry = r_expiry;
        w_tok[0]        = '0;
        w_tok[0].active = r_launch;
    end

    // Cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        mmat_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_bc     (w_bc),
            .i_commit (w_commit),
            .o_tok    (w_tok[g+1])
        );
    end

    // Decide the walk outcome when the token leaves the last cell
    assign w_last        = w_tok[TABLE_DEPTH];
    assign w_commit.fire = w_last.active;
    assign w_commit.keep = (r_bc.cmd == mmat_pkg::CMD_REPORT) && !w_last.hit && w_last.claimed;

    always_comb begin
        w_res = {w_last.count,
                 ((r_bc.cmd == mmat_pkg::CMD_REPORT) && r_bc.en && !w_last.hit &&
                  !w_last.claimed) ? mmat_pkg::STATUS_FULL : mmat_pkg::STATUS_DONE,
                 w_last.hit};
    end

    assign w_out_free = !r_m_valid || m_axis_tready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmat_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and output word loading
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_res_we      = 1'b0;
        n_m_res       = r_m_res;
        n_m_valid     = r_m_valid && !m_axis_tready;
        case (r_state)
            mmat_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = mmat_pkg::ST_WALK;
                end
            end
            mmat_pkg::ST_WALK: begin
                if (w_last.active) begin
                    if (w_out_free) begin
                        n_m_res   = w_res;
                        n_m_valid = 1'b1;
                        n_state   = mmat_pkg::ST_IDLE;
                    end else begin
                        w_res_we = 1'b1;
                        n_state  = mmat_pkg::ST_HOLD;
                    end
                end
            end
            mmat_pkg::ST_HOLD: begin
                if (w_out_free) begin
                    n_m_res   = r_res;
                    n_m_valid = 1'b1;
                    n_state   = mmat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mmat_pkg::ST_IDLE;
            end
        endcase
    end

    // Output word register and held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_res <= n_m_res;
        if (w_res_we) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(mmat_pkg::M_TDATA_W-RES_W){1'b0}}, r_m_res};

    // A token only ever leaves the chain during a walk
    a_tok_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.active |-> r_state == mmat_pkg::ST_WALK)
        else $error("token left the chain outside a walk");

    // Every accepted word launches a token next cycle while walking
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_launch && r_state == mmat_pkg::ST_WALK)
        else $error("accepted word did not launch a token");

    // A dropped report never claims to have found its entry
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("full status together with found");

    // A nonzero expired count comes only with found and status clear
    a_count_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[RES_W-1:2] != '0) |->
            (m_axis_tdata[1:0] == 2'b00))
        else $error("expired count on a non-sweep result");

endmodule

### rtl/core/mmat_cell.sv
module mmat_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mmat_pkg::t_tok    i_tok,
    input  mmat_pkg::t_bcast  i_bc,
    input  mmat_pkg::t_commit i_commit,
    output mmat_pkg::t_tok    o_tok
);

    logic                          r_valid;
    logic                          n_valid;
    logic                          r_pending;
    logic                          n_pending;
    logic [mmat_pkg::IFACE_W-1:0]  r_iface;
    logic [mmat_pkg::GROUP_W-1:0]  r_group;
    logic [mmat_pkg::TIME_W-1:0]   r_stamp;
    mmat_pkg::t_tok                r_tok;
    mmat_pkg::t_tok                n_tok;
    logic                          w_key_we;
    logic                          w_stamp_we;
    logic                          w_match;
    logic                          w_old;
    logic [mmat_pkg::TIME_W-1:0]   w_age;

    // Compare this entry against the broadcast key
    assign w_match = r_valid && i_bc.en && (r_iface == i_bc.iface) && (r_group == i_bc.group);
    assign w_age   = i_bc.now - r_stamp;
    assign w_old   = r_valid &&
                     (w_age > {{(mmat_pkg::TIME_W-mmat_pkg::EXPIRY_W){1'b0}}, i_bc.expiry});

    // Act on the passing token and on the end-of-walk commit
    always_comb begin
        n_tok      = i_tok;
        n_valid    = r_valid;
        n_pending  = r_pending;
        w_key_we   = 1'b0;
        w_stamp_we = 1'b0;
        if (i_tok.active) begin
            case (i_bc.cmd)
                mmat_pkg::CMD_SWEEP: begin
                    if (w_old) begin
                        n_valid = 1'b0;
                        if (i_tok.count != mmat_pkg::COUNT_MAX) begin
                            n_tok.count = i_tok.count + 1'b1;
                        end
                    end
                end
                mmat_pkg::CMD_REPORT: begin
                    if (w_match) begin
                        n_tok.hit  = 1'b1;
                        w_stamp_we = 1'b1;
                    end else if (!r_valid && !i_tok.claimed && i_bc.en) begin
                        // claim the lowest free slot, kept only if the walk finds no matching entry
                        n_tok.claimed = 1'b1;
                        n_pending     = 1'b1;
                        w_key_we      = 1'b1;
                        w_stamp_we    = 1'b1;
                    end
                end
                mmat_pkg::CMD_LEAVE: begin
                    if (w_match) begin
                        n_tok.hit = 1'b1;
                        n_valid   = 1'b0;
                    end
                end
                mmat_pkg::CMD_QUERY: begin
                    if (w_match) begin
                        n_tok.hit = 1'b1;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
        if (i_commit.fire && r_pending) begin
            n_pending = 1'b0;
            n_valid   = i_commit.keep;
        end
    end

    // Hold control state and the outgoing token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pending <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_valid   <= n_valid;
            r_pending <= n_pending;
            r_tok     <= n_tok;
        end
    end

    // Store entry payload
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_iface <= i_bc.iface;
            r_group <= i_bc.group;
        end
        if (w_stamp_we) begin
            r_stamp <= i_bc.now;
        end
    end

    assign o_tok = r_tok;

endmodule

### dv/membership_checker.sv
module membership_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int IFACE_COUNT = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_valid,
    input  logic                              i_s_ready,
    input  logic [mmat_pkg::S_TDATA_W-1:0]    i_s_data,
    input  logic [mmat_pkg::CMD_W-1:0]        i_s_user,
    input  logic                              i_m_valid,
    input  logic                              i_m_ready,
    input  logic [mmat_pkg::M_TDATA_W-1:0]    i_m_data,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [mmat_pkg::EXPIRY_W-1:0]     i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import mmat_pkg::*;

    typedef struct packed {
        logic               found;
        logic               status;
        logic [COUNT_W-1:0] expired;
    } t_answer;

    // Shadow copy of the membership table
    logic                slot_valid [TABLE_DEPTH];
    logic [IFACE_W-1:0]  slot_iface [TABLE_DEPTH];
    logic [GROUP_W-1:0]  slot_group [TABLE_DEPTH];
    logic [TIME_W-1:0]   slot_stamp [TABLE_DEPTH];
    logic [EXPIRY_W-1:0] expiry;

    t_answer answer_q [$];
    int      fail_count = 0;

    // Apply one command to the shadow table and return the answer it earns
    function automatic t_answer apply_command(t_cmd cmd, logic [IFACE_W-1:0] ifc,
                                              logic [GROUP_W-1:0] grp,
                                              logic [TIME_W-1:0] now);
        t_answer           ans;
        int                hit_slot;
        int                free_slot;
        logic [TIME_W-1:0] age;
        ans       = '0;
        hit_slot  = -1;
        free_slot = -1;
        if (cmd == CMD_SWEEP) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_valid[i]) begin
                    age = now - slot_stamp[i];
                    if (age > TIME_W'(expiry)) begin
                        slot_valid[i] = 1'b0;
                        if (ans.expired != COUNT_MAX)
                            ans.expired = ans.expired + 1'b1;
                    end
                end
            end
        end else if (int'(ifc) < IFACE_COUNT) begin
            // scan downward so the lowest matching and lowest free slot win
            for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                if (!slot_valid[i])
                    free_slot = i;
                else if (slot_iface[i] == ifc && slot_group[i] == grp)
                    hit_slot = i;
            end
            ans.found = (hit_slot >= 0);
            case (cmd)
                CMD_REPORT: begin
                    if (hit_slot >= 0) begin
                        slot_stamp[hit_slot] = now;
                    end else if (free_slot < 0) begin
                        ans.status = STATUS_FULL;
                    end else begin
                        slot_valid[free_slot] = 1'b1;
                        slot_iface[free_slot] = ifc;
                        slot_group[free_slot] = grp;
                        slot_stamp[free_slot] = now;
                    end
                end
                CMD_LEAVE: begin
                    if (hit_slot >= 0)
                        slot_valid[hit_slot] = 1'b0;
                end
                default: ;
            endcase
        end
        return ans;
    endfunction

    // Track config writes, predict on each command word, compare each result word
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_valid[i] = 1'b0;
            expiry = EXPIRY_RESET;
            answer_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                expiry = i_cfg_data;
            if (i_m_valid && i_m_ready) begin
                got.found   = i_m_data[0];
                got.status  = i_m_data[1];
                got.expired = i_m_data[COUNT_W+1:2];
                if (answer_q.size() == 0) begin
                    $error("result word with no command outstanding: %h", i_m_data);
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.expired !== want.expired) begin
                        $error("expired_count: expected %0d, got %0d",
                               want.expired, got.expired);
                        fail_count++;
                    end
                end
            end
            if (i_s_valid && i_s_ready)
                answer_q.push_back(apply_command(t_cmd'(i_s_user),
                                                 i_s_data[IFACE_W-1:0],
                                                 i_s_data[IFACE_W+GROUP_W-1:IFACE_W],
                                                 i_s_data[IFACE_W+GROUP_W+TIME_W-1:
                                                          IFACE_W+GROUP_W]));
            o_pending <= answer_q.size();
        end
        o_fail_count <= fail_count;
    end

endmodule

### dv/tb.sv
module tb;
    import mmat_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int IFACE_COUNT    = 16;
    localparam int LATENCY        = TABLE_DEPTH + 2;
    localparam int IDLE_LIMIT     = 4000;
    localparam int HOLDOFF_CYCLES = 500;
    localparam int ITEM_TARGET    = 1700;
    localparam int POOL_SIZE      = 96;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [EXPIRY_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int items_sent;
    int pace_mode;
    bit holdoff_req;

    logic [EXPIRY_W-1:0] expiry_cur;
    logic [TIME_W-1:0]   clock_now;
    logic [IFACE_W-1:0]  pool_iface [POOL_SIZE];
    logic [GROUP_W-1:0]  pool_group [POOL_SIZE];

    multicast_membership_aging_table_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IFACE_COUNT (IFACE_COUNT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    membership_checker #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IFACE_COUNT (IFACE_COUNT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_s_user     (s_axis_tuser),
        .i_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .i_m_data     (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle cycles before the next word: random, none, or none half the time
    function automatic int draw_gap(int mode);
        case (mode)
            0:       return $urandom_range(0, 19);
            1:       return 0;
            default: return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 19);
        endcase
    endfunction

    // Offer one command word and hold it until the block takes it
    task automatic send_word(t_cmd cmd, logic [IFACE_W-1:0] ifc, logic [GROUP_W-1:0] grp,
                             logic [TIME_W-1:0] now);
        int gap;
        gap = draw_gap(pace_mode);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - IFACE_W - GROUP_W - TIME_W){1'b0}}, now, grp, ifc};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Stop offering and wait until every result word is back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_expiry(logic [EXPIRY_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        expiry_cur = value;
    endtask

    // Mixed traffic over the key pool with a drifting clock; a little pure noise
    task automatic send_mixed();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, POOL_SIZE - 1);
        clock_now = clock_now + TIME_W'($urandom_range(0, int'(expiry_cur) / 16 + 3));
        if (pick < 4)
            send_word(t_cmd'($urandom_range(0, 3)), IFACE_W'($urandom), $urandom, $urandom);
        else if (pick < 48)
            send_word(CMD_REPORT, pool_iface[k], pool_group[k], clock_now);
        else if (pick < 62)
            send_word(CMD_LEAVE, pool_iface[k], pool_group[k], clock_now);
        else if (pick < 86)
            send_word(CMD_QUERY, pool_iface[k], pool_group[k], clock_now);
        else
            send_word(CMD_SWEEP, IFACE_W'($urandom), $urandom, clock_now);
    endtask

    // Overfill the table with distinct keys, probe it, then age everything out
    task automatic fill_table();
        logic [GROUP_W-1:0] base;
        base = $urandom;
        for (int i = 0; i < TABLE_DEPTH + 6; i++)
            send_word(CMD_REPORT, IFACE_W'(i), {base[GROUP_W-1:8], 8'(i)}, clock_now);
        for (int i = 0; i < 3; i++)
            send_word(CMD_QUERY, IFACE_W'(i * 31), {base[GROUP_W-1:8], 8'(i * 31)}, clock_now);
        clock_now = clock_now + 32'd70000;
        send_word(CMD_SWEEP, '0, '0, clock_now);
    endtask

    // Stimulus
    initial begin
        int phase;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_REPORT;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        items_sent  = 0;
        pace_mode   = 0;
        holdoff_req = 1'b0;
        expiry_cur  = EXPIRY_RESET;
        clock_now   = $urandom;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_iface[i] = IFACE_W'($urandom_range(0, IFACE_COUNT - 1));
            pool_group[i] = $urandom;
        end
        pool_iface[0] = '0;
        pool_group[0] = '0;
        pool_iface[1] = '1;
        pool_group[1] = '1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, refresh, misses, leave, slot reuse, sweeps
        send_word(CMD_QUERY,  4'd0,  32'h0000_0000, 32'h0000_0000);
        send_word(CMD_REPORT, 4'd0,  32'h0000_0000, 32'h0000_0000);
        send_word(CMD_REPORT, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_QUERY,  4'd15, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_REPORT, 4'd0,  32'h0000_0000, 32'd100);
        send_word(CMD_QUERY,  4'd1,  32'h0000_0000, 32'd100);
        send_word(CMD_QUERY,  4'd0,  32'h0000_0001, 32'd100);
        send_word(CMD_LEAVE,  4'd0,  32'h0000_0000, 32'd100);
        send_word(CMD_LEAVE,  4'd0,  32'h0000_0000, 32'd100);
        send_word(CMD_REPORT, 4'd3,  32'hE000_0001, 32'd5);
        send_word(CMD_QUERY,  4'd3,  32'hE000_0001, 32'd5);
        send_word(CMD_SWEEP,  4'd9,  32'h1234_5678, 32'd265);
        send_word(CMD_SWEEP,  4'd0,  32'h0000_0000, 32'd266);
        send_word(CMD_REPORT, 4'd7,  32'hEFFF_FFFF, 32'hFFFF_FFF0);
        send_word(CMD_SWEEP,  4'd0,  32'h0000_0000, 32'h0000_0010);
        send_word(CMD_SWEEP,  4'd0,  32'h0000_0000, 32'h0000_0200);
        send_word(CMD_QUERY,  4'd7,  32'hEFFF_FFFF, 32'h0000_0200);

        // Random phases, each under its own expiry setting
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_drain();
            case (phase)
                0:       write_expiry(16'd0);
                1:       write_expiry(16'd1);
                2:       write_expiry(16'hFFFF);
                3:       write_expiry(EXPIRY_RESET);
                default: write_expiry(($urandom_range(0, 3) == 0) ? EXPIRY_W'($urandom_range(0, 15))
                                                                   : EXPIRY_W'($urandom_range(1, 65535)));
            endcase
            pace_mode = $urandom_range(0, 2);
            if (phase == 0) begin
                // zero expiry: an age of zero survives, one second more does not
                send_word(CMD_REPORT, 4'd5, 32'hE100_0005, clock_now);
                send_word(CMD_SWEEP,  4'd0, 32'h0,         clock_now);
                send_word(CMD_SWEEP,  4'd0, 32'h0,         clock_now + 1);
            end
            if (phase == 2)
                holdoff_req = 1'b1;
            if (phase == 6)
                clock_now = 32'hFFFF_FF00;
            if (phase % 5 == 4)
                fill_table();
            repeat ($urandom_range(60, 120)) send_mixed();
            phase++;
        end

        wait_drain();
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("** multicast_membership_aging_table_unit: PASSED **");
        else
            $display("** multicast_membership_aging_table_unit: FAILED **");
        $finish;
    end

    // Result sink: random stalls, one long hold-off on request
    initial begin
        int stall;
        int served;
        int rx_mode;
        m_axis_tready <= 1'b0;
        served  = 0;
        rx_mode = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end
            stall = draw_gap(rx_mode);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            served++;
            if (served % 40 == 0)
                rx_mode = $urandom_range(0, 2);
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** multicast_membership_aging_table_unit: FAILED **");
        $finish;
    end

endmodule

### files.f
rtl/core/mmat_pkg.sv
rtl/core/mmat_cell.sv
rtl/core/multicast_membership_aging_table_unit.sv
dv/membership_checker.sv
dv/tb.sv
